>>> hdl/wcls_pkg.sv
// shared types, constants and helpers for the warmup cosine learning rate schedule
`timescale 1ns / 1ps
package wcls_pkg;

   localparam int STEP_BITS_DEF     = 24;
   localparam int RATE_BITS_DEF     = 32;
   localparam int PROGRESS_BITS_DEF = 16;

   localparam int FRAC_BITS      = 32;
   localparam int RATIO_BITS     = 17;
   localparam int CSR_DATA_BITS  = 48;
   localparam int CSR_INDEX_BITS = 2;
   localparam int TAYLOR_TERMS   = 7;
   localparam int COS_STAGES     = 4 + 3 * TAYLOR_TERMS;

   localparam logic [31:0]          PI_Q30     = 32'd3373259426;
   localparam logic [FRAC_BITS:0]   ONE_Q32    = 33'h1_0000_0000;
   localparam logic [RATIO_BITS-1:0] RATIO_FULL = 17'h1_0000;

   typedef enum logic [1:0] {
      MODE_CONST  = 2'd0,
      MODE_COSINE = 2'd1,
      MODE_LINEAR = 2'd2
   } mode_type;

   typedef enum logic [CSR_INDEX_BITS-1:0] {
      REG_BASE_RATE    = 2'd0,
      REG_WARMUP_RATIO = 2'd1,
      REG_TOTAL_STEPS  = 2'd2,
      REG_DECAY_MODE   = 2'd3
   } csr_index_type;

   typedef struct packed {
      logic warming;
      logic pfull;
   } div_tag_type;

   typedef struct packed {
      logic                 warming;
      logic [FRAC_BITS:0]   f_alt;
   } cos_tag_type;

   function automatic int taylor_div(input int k);
      return (2 * k - 1) * (2 * k);
   endfunction

endpackage

>>> hdl/wcls_div.sv
// pipelined restoring divider, one quotient bit per stage
`timescale 1ns / 1ps
module wcls_div import wcls_pkg::*; #(
   parameter int STEP_BITS = STEP_BITS_DEF
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 in_valid,
   input  logic [STEP_BITS-1:0] in_num,
   input  logic [STEP_BITS-1:0] in_den,
   input  div_tag_type          in_tag,
   output logic                 out_valid,
   output logic [FRAC_BITS-1:0] out_quot,
   output div_tag_type          out_tag
);

   logic                 valid_ff [0:FRAC_BITS];
   logic [STEP_BITS-1:0] rem_ff   [0:FRAC_BITS];
   logic [STEP_BITS-1:0] den_ff   [0:FRAC_BITS];
   logic [FRAC_BITS-1:0] quot_ff  [0:FRAC_BITS];
   div_tag_type          tag_ff   [0:FRAC_BITS];

   assign valid_ff[0] = in_valid;
   assign rem_ff[0]   = in_num;
   assign den_ff[0]   = in_den;
   assign quot_ff[0]  = '0;
   assign tag_ff[0]   = in_tag;

   for (genvar i = 0; i < FRAC_BITS; i++) begin : g_bit
      logic [STEP_BITS:0] shifted;
      logic [STEP_BITS:0] diff;
      logic               take;

      assign shifted = {rem_ff[i], 1'b0};
      assign diff    = shifted - {1'b0, den_ff[i]};
      assign take    = shifted >= {1'b0, den_ff[i]};

      always_ff @(posedge clock) begin
         if (reset) begin
            valid_ff[i+1] <= 1'b0;
         end else begin
            valid_ff[i+1] <= valid_ff[i];
         end
         rem_ff[i+1]  <= take ? diff[STEP_BITS-1:0] : shifted[STEP_BITS-1:0];
         den_ff[i+1]  <= den_ff[i];
         quot_ff[i+1] <= {quot_ff[i][FRAC_BITS-2:0], take};
         tag_ff[i+1]  <= tag_ff[i];
      end
   end

   assign out_valid = valid_ff[FRAC_BITS];
   assign out_quot  = quot_ff[FRAC_BITS];
   assign out_tag   = tag_ff[FRAC_BITS];

endmodule

>>> hdl/wcls_cos.sv
// pipelined taylor evaluation of (1 + cos(pi * p)) / 2 in q1.32
`timescale 1ns / 1ps
module wcls_cos import wcls_pkg::*; #(
   parameter int PROGRESS_BITS = PROGRESS_BITS_DEF
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     in_valid,
   input  logic [PROGRESS_BITS-1:0] in_prog,
   input  logic                     in_mirror,
   input  cos_tag_type              in_tag,
   output logic                     out_valid,
   output logic [FRAC_BITS:0]       out_half,
   output cos_tag_type              out_tag
);

   localparam int AW = PROGRESS_BITS + 32;
   localparam bit LAST_NEG = (TAYLOR_TERMS % 2) == 1;

   // angle and square
   logic [AW-1:0] angle_prod;
   logic [61:0]   sq_prod;
   logic [30:0]   t_ff;
   logic          t_valid_ff, t_mir_ff;
   cos_tag_type   t_tag_ff;
   logic [31:0]   t2_ff;
   logic          t2_valid_ff, t2_mir_ff;
   cos_tag_type   t2_tag_ff;

   assign angle_prod = AW'(PI_Q30) * AW'(in_prog);
   assign sq_prod    = 62'(t_ff) * 62'(t_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         t_valid_ff  <= 1'b0;
         t2_valid_ff <= 1'b0;
      end else begin
         t_valid_ff  <= in_valid;
         t2_valid_ff <= t_valid_ff;
      end
      t_ff      <= angle_prod[PROGRESS_BITS +: 31];
      t_mir_ff  <= in_mirror;
      t_tag_ff  <= in_tag;
      t2_ff     <= sq_prod[30 +: 32];
      t2_mir_ff <= t_mir_ff;
      t2_tag_ff <= t_tag_ff;
   end

   // taylor terms
   logic [30:0] term_s [0:TAYLOR_TERMS];
   logic [32:0] pos_s  [0:TAYLOR_TERMS];
   logic [32:0] neg_s  [0:TAYLOR_TERMS];
   logic [31:0] t2_s   [0:TAYLOR_TERMS];
   logic        mir_s  [0:TAYLOR_TERMS];
   logic        vld_s  [0:TAYLOR_TERMS];
   cos_tag_type tag_s  [0:TAYLOR_TERMS];

   assign term_s[0] = 31'h4000_0000;
   assign pos_s[0]  = 33'h0_4000_0000;
   assign neg_s[0]  = '0;
   assign t2_s[0]   = t2_ff;
   assign mir_s[0]  = t2_mir_ff;
   assign vld_s[0]  = t2_valid_ff;
   assign tag_s[0]  = t2_tag_ff;

   for (genvar k = 1; k <= TAYLOR_TERMS; k++) begin : g_term
      localparam int          DIV     = taylor_div(k);
      localparam logic [34:0] RECIP   = 35'((64'd1 << 34) / DIV);
      localparam bit          ADD_ANY = k > 1;
      localparam bit          ADD_NEG = ((k - 1) % 2) == 1;

      logic [62:0] x_prod;
      logic [67:0] q_prod;
      logic [32:0] back;
      logic [32:0] r;

      logic [32:0] a_x_ff, a_pos_ff, a_neg_ff;
      logic [31:0] a_t2_ff;
      logic        a_mir_ff, a_vld_ff;
      cos_tag_type a_tag_ff;

      logic [32:0] b_x_ff, b_q_ff, b_pos_ff, b_neg_ff;
      logic [31:0] b_t2_ff;
      logic        b_mir_ff, b_vld_ff;
      cos_tag_type b_tag_ff;

      assign x_prod = 63'(term_s[k-1]) * 63'(t2_s[k-1]);
      assign q_prod = 68'(a_x_ff) * 68'(RECIP);
      assign back   = b_q_ff * 33'(DIV);
      assign r      = b_x_ff - back;

      always_ff @(posedge clock) begin
         if (reset) begin
            a_vld_ff      <= 1'b0;
            b_vld_ff      <= 1'b0;
            vld_s[k]      <= 1'b0;
         end else begin
            a_vld_ff      <= vld_s[k-1];
            b_vld_ff      <= a_vld_ff;
            vld_s[k]      <= b_vld_ff;
         end
         a_x_ff   <= x_prod[30 +: 33];
         a_pos_ff <= pos_s[k-1] +
                     ((ADD_ANY && !ADD_NEG) ? 33'(term_s[k-1]) : 33'd0);
         a_neg_ff <= neg_s[k-1] +
                     ((ADD_ANY && ADD_NEG) ? 33'(term_s[k-1]) : 33'd0);
         a_t2_ff  <= t2_s[k-1];
         a_mir_ff <= mir_s[k-1];
         a_tag_ff <= tag_s[k-1];

         b_x_ff   <= a_x_ff;
         b_q_ff   <= q_prod[34 +: 33];
         b_pos_ff <= a_pos_ff;
         b_neg_ff <= a_neg_ff;
         b_t2_ff  <= a_t2_ff;
         b_mir_ff <= a_mir_ff;
         b_tag_ff <= a_tag_ff;

         term_s[k] <= (r >= 33'(DIV)) ? 31'(b_q_ff + 33'd1) : 31'(b_q_ff);
         pos_s[k]  <= b_pos_ff;
         neg_s[k]  <= b_neg_ff;
         t2_s[k]   <= b_t2_ff;
         mir_s[k]  <= b_mir_ff;
         tag_s[k]  <= b_tag_ff;
      end
   end

   // final sum, clamp and mirror
   logic [32:0]        f1_pos_ff, f1_neg_ff;
   logic               f1_mir_ff, f1_vld_ff;
   cos_tag_type        f1_tag_ff;
   logic [32:0]        c_raw;
   logic [30:0]        c_clamp;
   logic [FRAC_BITS:0] h_low;
   logic [FRAC_BITS:0] half_ff;
   logic               half_vld_ff;
   cos_tag_type        half_tag_ff;

   assign c_raw   = (f1_pos_ff >= f1_neg_ff) ? f1_pos_ff - f1_neg_ff : 33'd0;
   assign c_clamp = (c_raw > 33'h0_4000_0000) ? 31'h4000_0000 : 31'(c_raw);
   assign h_low   = 33'h0_8000_0000 + {1'b0, c_clamp, 1'b0};

   always_ff @(posedge clock) begin
      if (reset) begin
         f1_vld_ff   <= 1'b0;
         half_vld_ff <= 1'b0;
      end else begin
         f1_vld_ff   <= vld_s[TAYLOR_TERMS];
         half_vld_ff <= f1_vld_ff;
      end
      f1_pos_ff   <= pos_s[TAYLOR_TERMS] +
                     (!LAST_NEG ? 33'(term_s[TAYLOR_TERMS]) : 33'd0);
      f1_neg_ff   <= neg_s[TAYLOR_TERMS] +
                     (LAST_NEG ? 33'(term_s[TAYLOR_TERMS]) : 33'd0);
      f1_mir_ff   <= mir_s[TAYLOR_TERMS];
      f1_tag_ff   <= tag_s[TAYLOR_TERMS];
      half_ff     <= f1_mir_ff ? ONE_Q32 - h_low : h_low;
      half_tag_ff <= f1_tag_ff;
   end

   assign out_valid = half_vld_ff;
   assign out_half  = half_ff;
   assign out_tag   = half_tag_ff;

endmodule

>>> hdl/warmup_cosine_lr_schedule.sv
// top level: linear warmup then cosine, linear or constant learning rate decay
//
//  channel  | ports                         | transfer
//  ---------+-------------------------------+-----------------------------------
//  request  | req_start, busy, req_step_*   | edge with req_start high, busy low
//  response | rsp_valid, rsp_*              | one-cycle strobe, no back pressure
//  config   | csr_valid, csr_ready, csr_*   | edge with csr_valid and csr_ready
//
//  one request per cycle while busy is low; each response passes through these stages:
//  3 front stages, 32 divider stages, 1 select stage, 25 cosine stages, 2 multiply stages
//  the 32-stage divider and the seven-term taylor pipeline set the latency
//  synchronous reset clears all valid bits and loads the register defaults
//  busy is set during reset and cleared by the first clock edge without reset; responses are never stalled
`timescale 1ns / 1ps
module warmup_cosine_lr_schedule import wcls_pkg::*; #(
   parameter int STEP_BITS     = STEP_BITS_DEF,
   parameter int RATE_BITS     = RATE_BITS_DEF,
   parameter int PROGRESS_BITS = PROGRESS_BITS_DEF
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_start,
   output logic                      busy,
   input  logic [STEP_BITS-1:0]      req_step_index,
   output logic                      rsp_valid,
   output logic [RATE_BITS-1:0]      rsp_learning_rate,
   output logic                      rsp_in_warmup,
   input  logic                      csr_valid,
   output logic                      csr_ready,
   input  logic [CSR_INDEX_BITS-1:0] csr_index,
   input  logic [CSR_DATA_BITS-1:0]  csr_wdata
);

   localparam int PW = STEP_BITS + RATIO_BITS;
   localparam int HW = RATE_BITS + 17;
   localparam int LW = RATE_BITS + 16;
   localparam int LATENCY = 3 + FRAC_BITS + 1 + COS_STAGES + 2;
   localparam logic [PROGRESS_BITS:0] PROG_FULL = (PROGRESS_BITS+1)'(1) << PROGRESS_BITS;
   localparam logic [PROGRESS_BITS:0] PROG_HALF = PROG_FULL >> 1;

   // configuration registers
   logic [RATE_BITS-1:0]  base_rate_ff;
   logic [RATIO_BITS-1:0] warmup_ratio_ff;
   logic [STEP_BITS-1:0]  total_steps_ff;
   logic [1:0]            decay_mode_ff;
   logic                  busy_ff;

   assign csr_ready = 1'b1;
   assign busy      = busy_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         base_rate_ff    <= '0;
         warmup_ratio_ff <= '0;
         total_steps_ff  <= STEP_BITS'(1);
         decay_mode_ff   <= MODE_CONST;
         busy_ff         <= 1'b1;
      end else begin
         busy_ff <= 1'b0;
         if (csr_valid && csr_ready) begin
            case (csr_index_type'(csr_index))
               REG_BASE_RATE:    base_rate_ff    <= csr_wdata[RATE_BITS-1:0];
               REG_WARMUP_RATIO: warmup_ratio_ff <= csr_wdata[RATIO_BITS-1:0];
               REG_TOTAL_STEPS:  total_steps_ff  <= csr_wdata[STEP_BITS-1:0];
               REG_DECAY_MODE:   decay_mode_ff   <= csr_wdata[1:0];
               default: ;
            endcase
         end
      end
   end

   // front stages: warmup length, span, divider operands
   logic                  accept;
   logic [RATIO_BITS-1:0] ratio_sat;
   logic                  s0_valid_ff;
   logic [STEP_BITS-1:0]  s0_step_ff;
   logic [PW-1:0]         s0_prod_ff;
   logic [STEP_BITS-1:0]  s1_warm_in;
   logic                  s1_valid_ff, s1_warming_ff;
   logic [STEP_BITS-1:0]  s1_step_ff, s1_warm_ff, s1_span_ff, s1_done_ff;
   logic                  s2_valid_ff, s2_warming_ff, s2_pfull_ff;
   logic [STEP_BITS-1:0]  s2_num_ff, s2_den_ff;

   assign accept     = req_start && !busy_ff;
   assign ratio_sat  = (warmup_ratio_ff > RATIO_FULL) ? RATIO_FULL : warmup_ratio_ff;
   assign s1_warm_in = s0_prod_ff[16 +: STEP_BITS];

   always_ff @(posedge clock) begin
      if (reset) begin
         s0_valid_ff <= 1'b0;
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
      end else begin
         s0_valid_ff <= accept;
         s1_valid_ff <= s0_valid_ff;
         s2_valid_ff <= s1_valid_ff;
      end
      s0_step_ff    <= req_step_index;
      s0_prod_ff    <= PW'(total_steps_ff) * PW'(ratio_sat);

      s1_step_ff    <= s0_step_ff;
      s1_warm_ff    <= s1_warm_in;
      s1_warming_ff <= s0_step_ff < s1_warm_in;
      s1_span_ff    <= total_steps_ff - s1_warm_in;
      s1_done_ff    <= s0_step_ff - s1_warm_in;

      s2_warming_ff <= s1_warming_ff;
      s2_pfull_ff   <= !s1_warming_ff &&
                       (s1_span_ff == '0 || s1_done_ff >= s1_span_ff);
      s2_num_ff     <= s1_warming_ff ? s1_step_ff : s1_done_ff;
      s2_den_ff     <= s1_warming_ff ? s1_warm_ff : s1_span_ff;
   end

   // divider
   div_tag_type          div_in_tag, div_out_tag;
   logic                 div_out_valid;
   logic [FRAC_BITS-1:0] div_out_quot;

   assign div_in_tag = '{warming: s2_warming_ff, pfull: s2_pfull_ff};

   wcls_div #(.STEP_BITS(STEP_BITS)) u_div (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (s2_valid_ff),
      .in_num    (s2_num_ff),
      .in_den    (s2_den_ff),
      .in_tag    (div_in_tag),
      .out_valid (div_out_valid),
      .out_quot  (div_out_quot),
      .out_tag   (div_out_tag)
   );

   // progress, mirror and non-cosine factor
   logic [PROGRESS_BITS:0]   prog_in, prog_low_in;
   logic                     mirror_in;
   logic [FRAC_BITS:0]       f_alt_in;
   logic                     s3_valid_ff, s3_mirror_ff;
   logic [PROGRESS_BITS-1:0] s3_prog_ff;
   cos_tag_type              s3_tag_ff;

   assign prog_in     = div_out_tag.pfull ? PROG_FULL :
                        {1'b0, div_out_quot[FRAC_BITS-1 -: PROGRESS_BITS]};
   assign mirror_in   = prog_in > PROG_HALF;
   assign prog_low_in = mirror_in ? PROG_FULL - prog_in : prog_in;

   always_comb begin
      if (div_out_tag.warming) begin
         f_alt_in = {1'b0, div_out_quot};
      end else if (decay_mode_ff == MODE_LINEAR) begin
         f_alt_in = (FRAC_BITS+1)'(PROG_FULL - prog_in) << (FRAC_BITS - PROGRESS_BITS);
      end else begin
         f_alt_in = ONE_Q32;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s3_valid_ff <= 1'b0;
      end else begin
         s3_valid_ff <= div_out_valid;
      end
      s3_prog_ff   <= prog_low_in[PROGRESS_BITS-1:0];
      s3_mirror_ff <= mirror_in;
      s3_tag_ff    <= '{warming: div_out_tag.warming, f_alt: f_alt_in};
   end

   // cosine
   logic               cos_valid;
   logic [FRAC_BITS:0] cos_half;
   cos_tag_type        cos_tag;

   wcls_cos #(.PROGRESS_BITS(PROGRESS_BITS)) u_cos (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (s3_valid_ff),
      .in_prog   (s3_prog_ff),
      .in_mirror (s3_mirror_ff),
      .in_tag    (s3_tag_ff),
      .out_valid (cos_valid),
      .out_half  (cos_half),
      .out_tag   (cos_tag)
   );

   // rate = floor(base * f / 2^32)
   logic [FRAC_BITS:0]   f_sel;
   logic                 m1_valid_ff, m1_warm_ff;
   logic [HW-1:0]        m1_hi_ff;
   logic [LW-1:0]        m1_lo_ff;
   logic [HW-1:0]        m2_sum_in;
   logic                 rsp_valid_ff, rsp_in_warmup_ff;
   logic [RATE_BITS-1:0] rsp_learning_rate_ff;

   assign f_sel     = (!cos_tag.warming && decay_mode_ff == MODE_COSINE) ?
                      cos_half : cos_tag.f_alt;
   assign m2_sum_in = m1_hi_ff + HW'(m1_lo_ff >> 16);

   always_ff @(posedge clock) begin
      if (reset) begin
         m1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         m1_valid_ff  <= cos_valid;
         rsp_valid_ff <= m1_valid_ff;
      end
      m1_hi_ff             <= HW'(base_rate_ff) * HW'(f_sel[FRAC_BITS:16]);
      m1_lo_ff             <= LW'(base_rate_ff) * LW'(f_sel[15:0]);
      m1_warm_ff           <= cos_tag.warming;
      rsp_learning_rate_ff <= m2_sum_in[16 +: RATE_BITS];
      rsp_in_warmup_ff     <= m1_warm_ff;
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_learning_rate = rsp_learning_rate_ff;
   assign rsp_in_warmup     = rsp_in_warmup_ff;

   a_latency: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(accept, LATENCY))
      else $error("response without matching request");

   a_div_operands: assert property (@(posedge clock) disable iff (reset)
      (s2_valid_ff && !s2_pfull_ff) |-> (s2_num_ff < s2_den_ff))
      else $error("divider operands out of range");

   a_full_factor: assert property (@(posedge clock) disable iff (reset)
      (cos_valid && f_sel == ONE_Q32) |-> ##2 (rsp_learning_rate == $past(base_rate_ff, 2)))
      else $error("full factor does not give base rate");

endmodule
